[rtl/core/pse_pkg.sv]
package pse_pkg;

   localparam int SCREEN_COLS = 40;
   localparam int SCREEN_ROWS = 25;
   localparam int CELLS       = SCREEN_ROWS * SCREEN_COLS;
   localparam int ADDR_W      = $clog2(CELLS);
   localparam int ROW_W       = 5;
   localparam int COL_W       = 6;
   localparam int GLYPH_W     = 8;

   localparam logic [GLYPH_W-1:0] CH_RETURN  = 8'd10;
   localparam logic [GLYPH_W-1:0] CH_DOWN    = 8'd17;
   localparam logic [GLYPH_W-1:0] CH_HOME    = 8'd19;
   localparam logic [GLYPH_W-1:0] CH_DELETE  = 8'd20;
   localparam logic [GLYPH_W-1:0] CH_CTRL_MAX = 8'd26;
   localparam logic [GLYPH_W-1:0] CH_RIGHT   = 8'd29;
   localparam logic [GLYPH_W-1:0] CH_BLANK   = 8'd32;
   localparam logic [GLYPH_W-1:0] CH_QUOTE   = 8'd34;
   localparam logic [GLYPH_W-1:0] CH_BAR     = 8'd124;
   localparam logic [GLYPH_W-1:0] CH_FKEY_LO = 8'd133;
   localparam logic [GLYPH_W-1:0] CH_FKEY_HI = 8'd140;
   localparam logic [GLYPH_W-1:0] CH_UP      = 8'd145;
   localparam logic [GLYPH_W-1:0] CH_CLEAR   = 8'd147;
   localparam logic [GLYPH_W-1:0] CH_INSERT  = 8'd148;
   localparam logic [GLYPH_W-1:0] CH_LEFT    = 8'd157;

   // memory phase the datapath runs: idle, a wipe, copy or fill sweep, or a read
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_WIPE      = 3'd1,
      PH_EDIT_COPY = 3'd2,
      PH_EDIT_FILL = 3'd3,
      PH_SCRL_COPY = 3'd4,
      PH_SCRL_FILL = 3'd5,
      PH_READ      = 3'd6
   } phase_type;

   typedef struct packed {
      logic      accept;
      logic      load;
      phase_type load_ph;
      phase_type ph;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic clear;
      logic ed_copy;
      logic ed_fill;
      logic scroll;
   } status_type;

endpackage

[rtl/core/pse_ctrl.sv]
module pse_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_action,
   input  pse_pkg::status_type sts,
   output pse_pkg::cmd_type   cmd,
   output logic               busy,
   output logic               rsp_strobe
);
   import pse_pkg::*;

   typedef enum logic [9:0] {
      ST_INIT      = 10'b00_0000_0001,
      ST_IDLE      = 10'b00_0000_0010,
      ST_PLAN      = 10'b00_0000_0100,
      ST_WIPE      = 10'b00_0000_1000,
      ST_EDIT_COPY = 10'b00_0001_0000,
      ST_EDIT_FILL = 10'b00_0010_0000,
      ST_SCRL_COPY = 10'b00_0100_0000,
      ST_SCRL_FILL = 10'b00_1000_0000,
      ST_READ      = 10'b01_0000_0000,
      ST_RESP      = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   function automatic phase_type ph_of(input state_type s);
      phase_type p;
      case (s)
         ST_INIT:      p = PH_WIPE;
         ST_WIPE:      p = PH_WIPE;
         ST_EDIT_COPY: p = PH_EDIT_COPY;
         ST_EDIT_FILL: p = PH_EDIT_FILL;
         ST_SCRL_COPY: p = PH_SCRL_COPY;
         ST_SCRL_FILL: p = PH_SCRL_FILL;
         ST_READ:      p = PH_READ;
         default:      p = PH_IDLE;
      endcase
      return p;
   endfunction

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      case (state_ff)
         ST_INIT: begin
            if (sts.last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = req_action ? ST_READ : ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (sts.clear)        state_in = ST_WIPE;
            else if (sts.ed_copy) state_in = ST_EDIT_COPY;
            else if (sts.ed_fill) state_in = ST_EDIT_FILL;
            else if (sts.scroll)  state_in = ST_SCRL_COPY;
            else                  state_in = ST_RESP;
         end
         ST_WIPE: begin
            if (sts.last) state_in = ST_RESP;
         end
         ST_EDIT_COPY: begin
            if (sts.last) state_in = ST_EDIT_FILL;
         end
         ST_EDIT_FILL: begin
            if (sts.last) state_in = sts.scroll ? ST_SCRL_COPY : ST_RESP;
         end
         ST_SCRL_COPY: begin
            if (sts.last) state_in = ST_SCRL_FILL;
         end
         ST_SCRL_FILL: begin
            if (sts.last) state_in = ST_RESP;
         end
         ST_READ: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase

      // load the sweep pointer when entering a sweep state
      cmd.ph      = ph_of(state_ff);
      cmd.load_ph = ph_of(state_in);
      cmd.load    = (state_in != state_ff) && (cmd.load_ph != PH_IDLE) &&
                    (cmd.load_ph != PH_READ);
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_INIT;
      else       state_ff <= state_in;
   end

endmodule

[rtl/core/pse_dpath.sv]
module pse_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  pse_pkg::cmd_type             cmd,
   input  logic                         req_action,
   input  logic [pse_pkg::GLYPH_W-1:0]  req_char_code,
   input  logic [pse_pkg::ROW_W-1:0]    req_read_row,
   input  logic [pse_pkg::COL_W-1:0]    req_read_col,
   output pse_pkg::status_type          sts,
   output logic [pse_pkg::GLYPH_W-1:0]  rsp_cell_glyph,
   output logic [pse_pkg::ROW_W-1:0]    rsp_cursor_row_out,
   output logic [pse_pkg::COL_W-1:0]    rsp_cursor_col_out,
   output logic                         rsp_quote_active
);
   import pse_pkg::*;

   typedef enum logic [1:0] {
      DELTA_DEC1 = 2'd0,
      DELTA_INC1 = 2'd1,
      DELTA_ROW  = 2'd2
   } delta_type;

   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLS);
   localparam logic [ADDR_W-1:0] LAST_A    = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LROW_A    = ADDR_W'(CELLS - SCREEN_COLS);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLS - 1);
   localparam logic [ADDR_W-1:0] LCOL_A    = ADDR_W'(SCREEN_COLS - 1);

   logic [GLYPH_W-1:0] mem [CELLS];

   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               quote_ff, quote_in;
   logic               clear_ff, clear_in;
   logic               ed_copy_ff, ed_copy_in;
   logic               ed_fill_ff, ed_fill_in;
   logic               scroll_ff, scroll_in;
   delta_type          mode_ff, mode_in;
   logic [ADDR_W-1:0]  first_ff, first_in;
   logic [ADDR_W-1:0]  last_ff, last_in;
   logic [ADDR_W-1:0]  fill_addr_ff, fill_addr_in;
   logic [GLYPH_W-1:0] fill_data_ff, fill_data_in;
   logic [ADDR_W-1:0]  rd_req_ff, rd_req_in;
   logic               is_read_ff;
   logic               in_range_ff, in_range_in;

   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  dst_ff, dst_in;
   logic [GLYPH_W-1:0] rd_data_ff;

   logic [GLYPH_W-1:0] code;
   logic               special;
   logic [ROW_W-1:0]   lrow;
   logic [COL_W-1:0]   lcol;
   logic [ADDR_W-1:0]  base, lbase;

   // request decode: cursor, quote mode and the sweeps the request needs
   always_comb begin
      quote_in = quote_ff ^ (req_char_code == CH_QUOTE);
      if (quote_in && (req_char_code == CH_RETURN)) quote_in = 1'b0;
      special = (req_char_code == CH_UP) || (req_char_code == CH_RIGHT) ||
                (req_char_code == CH_LEFT) || (req_char_code == CH_DOWN) ||
                (req_char_code == CH_INSERT) || (req_char_code == CH_HOME) ||
                (req_char_code == CH_CLEAR) ||
                ((req_char_code >= CH_FKEY_LO) && (req_char_code <= CH_FKEY_HI));
      code = (quote_in && special) ? CH_BAR : req_char_code;

      lrow = row_ff;
      lcol = col_ff;
      if (col_ff != '0) begin
         lcol = col_ff - 1'b1;
      end else if (row_ff != '0) begin
         lrow = row_ff - 1'b1;
         lcol = LAST_COL;
      end
      base  = ADDR_W'(row_ff) * COLS_A;
      lbase = ADDR_W'(lrow) * COLS_A;

      row_in       = row_ff;
      col_in       = col_ff;
      clear_in     = 1'b0;
      ed_copy_in   = 1'b0;
      ed_fill_in   = 1'b0;
      scroll_in    = 1'b0;
      mode_in      = DELTA_DEC1;
      first_in     = '0;
      last_in      = '0;
      fill_addr_in = base + ADDR_W'(col_ff);
      fill_data_in = CH_BLANK;

      case (code)
         CH_DELETE: begin
            row_in = lrow;
            col_in = lcol;
            if (lcol != LAST_COL) begin
               ed_copy_in   = 1'b1;
               ed_fill_in   = 1'b1;
               mode_in      = DELTA_DEC1;
               first_in     = lbase + ADDR_W'(lcol) + 1'b1;
               last_in      = lbase + LCOL_A;
               fill_addr_in = lbase + LCOL_A;
            end
         end
         CH_UP: begin
            if (row_ff != '0) row_in = row_ff - 1'b1;
         end
         CH_LEFT: begin
            row_in = lrow;
            col_in = lcol;
         end
         CH_RIGHT: begin
            if (col_ff != LAST_COL) begin
               col_in = col_ff + 1'b1;
            end else begin
               col_in = '0;
               if (row_ff != LAST_ROW) row_in = row_ff + 1'b1;
               else                    scroll_in = 1'b1;
            end
         end
         CH_DOWN: begin
            if (row_ff != LAST_ROW) row_in = row_ff + 1'b1;
            else                    scroll_in = 1'b1;
         end
         CH_RETURN: begin
            col_in = '0;
            if (row_ff != LAST_ROW) row_in = row_ff + 1'b1;
            else                    scroll_in = 1'b1;
         end
         CH_INSERT: begin
            ed_fill_in = 1'b1;
            if (col_ff != LAST_COL) begin
               ed_copy_in = 1'b1;
               mode_in    = DELTA_INC1;
               first_in   = base + LCOL_A - 1'b1;
               last_in    = base + ADDR_W'(col_ff);
            end
         end
         CH_HOME: begin
            row_in = '0;
            col_in = '0;
         end
         CH_CLEAR: begin
            row_in   = '0;
            col_in   = '0;
            clear_in = 1'b1;
         end
         default: begin
            if ((code > CH_CTRL_MAX) && ((code < CH_FKEY_LO) || (code > CH_FKEY_HI))) begin
               ed_fill_in   = 1'b1;
               fill_data_in = code;
               if (col_ff != LAST_COL) begin
                  col_in = col_ff + 1'b1;
               end else begin
                  col_in = '0;
                  if (row_ff != LAST_ROW) row_in = row_ff + 1'b1;
                  else                    scroll_in = 1'b1;
               end
            end
         end
      endcase

      in_range_in = (32'(req_read_row) < SCREEN_ROWS) && (32'(req_read_col) < SCREEN_COLS);
      rd_req_in   = in_range_in ?
                    ADDR_W'(req_read_row) * COLS_A + ADDR_W'(req_read_col) : '0;
   end

   // sweep engine: copies read one cell a cycle and write it back in the next cycle
   logic               copy_ph, fill_ph, asc;
   delta_type          cmode;
   logic [ADDR_W-1:0]  copy_end, fill_end, rd_addr, wr_addr;
   logic [GLYPH_W-1:0] wr_data;
   logic               wr_en;

   always_comb begin
      copy_ph  = (cmd.ph == PH_EDIT_COPY) || (cmd.ph == PH_SCRL_COPY);
      fill_ph  = (cmd.ph == PH_WIPE) || (cmd.ph == PH_EDIT_FILL) ||
                 (cmd.ph == PH_SCRL_FILL);
      cmode    = (cmd.ph == PH_EDIT_COPY) ? mode_ff : DELTA_ROW;
      asc      = (cmode != DELTA_INC1);
      copy_end = (cmd.ph == PH_EDIT_COPY) ? last_ff : LAST_A;
      fill_end = (cmd.ph == PH_EDIT_FILL) ? fill_addr_ff : LAST_A;

      case (cmode)
         DELTA_DEC1: dst_in = ptr_ff - 1'b1;
         DELTA_INC1: dst_in = ptr_ff + 1'b1;
         DELTA_ROW:  dst_in = ptr_ff - COLS_A;
         default:    dst_in = ptr_ff;
      endcase
      pend_in = copy_ph;

      ptr_in = ptr_ff;
      if (cmd.load) begin
         case (cmd.load_ph)
            PH_WIPE:      ptr_in = '0;
            PH_EDIT_COPY: ptr_in = first_ff;
            PH_EDIT_FILL: ptr_in = fill_addr_ff;
            PH_SCRL_COPY: ptr_in = COLS_A;
            PH_SCRL_FILL: ptr_in = LROW_A;
            default:      ptr_in = ptr_ff;
         endcase
      end else if (copy_ph) begin
         ptr_in = asc ? ptr_ff + 1'b1 : ptr_ff - 1'b1;
      end else if (fill_ph && !pend_ff) begin
         ptr_in = ptr_ff + 1'b1;
      end

      // the trailing copy write goes first, the fill holds for it
      wr_en   = pend_ff || fill_ph;
      wr_addr = pend_ff ? dst_ff : ptr_ff;
      wr_data = pend_ff ? rd_data_ff :
                (cmd.ph == PH_EDIT_FILL) ? fill_data_ff : CH_BLANK;
      rd_addr = (cmd.ph == PH_READ) ? rd_req_ff : ptr_ff;

      sts.last    = (copy_ph && (ptr_ff == copy_end)) ||
                    (fill_ph && !pend_ff && (ptr_ff == fill_end));
      sts.clear   = clear_ff;
      sts.ed_copy = ed_copy_ff;
      sts.ed_fill = ed_fill_ff;
      sts.scroll  = scroll_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         quote_ff   <= 1'b0;
         clear_ff   <= 1'b0;
         ed_copy_ff <= 1'b0;
         ed_fill_ff <= 1'b0;
         scroll_ff  <= 1'b0;
         is_read_ff <= 1'b0;
         ptr_ff     <= '0;
         pend_ff    <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         pend_ff <= pend_in;
         if (cmd.accept) begin
            is_read_ff <= req_action;
            if (!req_action) begin
               row_ff     <= row_in;
               col_ff     <= col_in;
               quote_ff   <= quote_in;
               clear_ff   <= clear_in;
               ed_copy_ff <= ed_copy_in;
               ed_fill_ff <= ed_fill_in;
               scroll_ff  <= scroll_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      dst_ff <= dst_in;
      if (cmd.accept) begin
         mode_ff      <= mode_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         fill_addr_ff <= fill_addr_in;
         fill_data_ff <= fill_data_in;
         rd_req_ff    <= rd_req_in;
         in_range_ff  <= in_range_in;
      end
   end

   assign rsp_cell_glyph     = (is_read_ff && in_range_ff) ? rd_data_ff : '0;
   assign rsp_cursor_row_out = row_ff;
   assign rsp_cursor_col_out = col_ff;
   assign rsp_quote_active   = quote_ff;

endmodule

[rtl/core/petscii_text_screen_editor_unit.sv]
// Channel   Ports                                   Handshake
// request   req_action req_char_code req_read_row    start high while busy low
//           req_read_col
// response  rsp_cell_glyph rsp_cursor_row_out       rsp_strobe, one cycle, no stall
//           rsp_cursor_col_out rsp_quote_active
//
// A read passes a read state, and a feed that only moves the cursor a plan state, before
// the response state; a character write adds a one-cell fill. A row shift on delete or
// insert adds a copy sweep over the moved cells and a fill; a scroll copies the screen up a
// row and blanks the last, a clear blanks it all, each through the single write port of the
// 1000-cell screen memory. After reset a clearing pass blanks the memory with busy high.
// The response cannot be held off; the next request is taken the cycle after the strobe.
module petscii_text_screen_editor_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_action,
   input  logic [pse_pkg::GLYPH_W-1:0] req_char_code,
   input  logic [pse_pkg::ROW_W-1:0]   req_read_row,
   input  logic [pse_pkg::COL_W-1:0]   req_read_col,
   output logic                        rsp_strobe,
   output logic [pse_pkg::GLYPH_W-1:0] rsp_cell_glyph,
   output logic [pse_pkg::ROW_W-1:0]   rsp_cursor_row_out,
   output logic [pse_pkg::COL_W-1:0]   rsp_cursor_col_out,
   output logic                        rsp_quote_active
);
   import pse_pkg::*;

   cmd_type    cmd;
   status_type sts;

   pse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   pse_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_action         (req_action),
      .req_char_code      (req_char_code),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .sts                (sts),
      .rsp_cell_glyph     (rsp_cell_glyph),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .rsp_quote_active   (rsp_quote_active)
   );

endmodule
